// ===== rtl/tempered_log_weight_reweighter_defines.svh =====
// assertion macros for the reweighter
`ifndef TEMPERED_LOG_WEIGHT_REWEIGHTER_DEFINES_SVH
`define TEMPERED_LOG_WEIGHT_REWEIGHTER_DEFINES_SVH

`ifndef SYNTHESIS
`define TLWR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tlwr assertion failed");
`define TLWR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tlwr assertion failed");
`else
`define TLWR_ASSERT(lbl, prop)
`define TLWR_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== rtl/tlwr_pkg.sv =====
package tlwr_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_SUM,
    ST_POST,
    ST_RD,
    ST_RD_DATA,
    ST_CMP,
    ST_SOFT,
    ST_SP_ADD,
    ST_FINAL
  } tlwr_state_t;

  // register indexes of the configuration port
  localparam logic [2:0] REG_MODE          = 3'd0;
  localparam logic [2:0] REG_BETA_SIM      = 3'd1;
  localparam logic [2:0] REG_BETA_TARGET   = 3'd2;
  localparam logic [2:0] REG_ENERGY_SHIFT  = 3'd3;
  localparam logic [2:0] REG_WEIGHT_OFFSET = 3'd4;
  localparam logic [2:0] REG_REPLICA_COUNT = 3'd5;

  // weighting modes
  localparam logic [1:0] MODE_BIAS_SUM = 2'd0;
  localparam logic [1:0] MODE_TWO_TEMP = 2'd1;
  localparam logic [1:0] MODE_REPLICA  = 2'd2;

  // op codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam int SP_STEPS = 24;

  // ln(1+exp(-k/2)) in Q0.16
  function automatic logic [15:0] sp_base(input logic [4:0] k);
    logic [15:0] v;
    unique case (k)
      5'd0:  v = 16'd45426;
      5'd1:  v = 16'd31069;
      5'd2:  v = 16'd20530;
      5'd3:  v = 16'd13200;
      5'd4:  v = 16'd8318;
      5'd5:  v = 16'd5170;
      5'd6:  v = 16'd3184;
      5'd7:  v = 16'd1950;
      5'd8:  v = 16'd1189;
      5'd9:  v = 16'd724;
      5'd10: v = 16'd440;
      5'd11: v = 16'd267;
      5'd12: v = 16'd162;
      5'd13: v = 16'd98;
      5'd14: v = 16'd60;
      5'd15: v = 16'd36;
      5'd16: v = 16'd22;
      5'd17: v = 16'd13;
      5'd18: v = 16'd8;
      5'd19: v = 16'd5;
      5'd20: v = 16'd3;
      5'd21: v = 16'd2;
      5'd22: v = 16'd1;
      5'd23: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/tempered_log_weight_reweighter.sv =====
// tempered log-weight reweighter, signed fixed point with FRAC_BITS fraction bits.
// an item is taken when start is high while busy is low. a load (op 0) writes one
// replica entry and answers on the next cycle with weight_valid low; loads run
// back to back. a sample (op 1) answers with done for one cycle, which the
// receiver cannot stall, so it must take the result in that cycle. one shared
// multiplier, split into two partial products, serves every product; the replica
// log-sum-exp mode makes a per-entry walk of table read, multiply, compare and
// interpolated soft-plus
`include "tempered_log_weight_reweighter_defines.svh"

module tempered_log_weight_reweighter #(
  parameter int MAX_REPLICAS = 64,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  // item transfer
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [5:0]         entry_index,
  input  logic signed [31:0] entry_offset,
  input  logic signed [31:0] entry_beta,
  input  logic signed [31:0] first_term,
  input  logic signed [31:0] second_term,
  input  logic signed [31:0] rest_sum,
  // result transfer
  output logic               done,
  output logic signed [31:0] log_weight,
  output logic               weight_valid,
  output logic               saturated,
  // configuration writes
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import tlwr_pkg::*;

  localparam int IDX_W = $clog2(MAX_REPLICAS);
  localparam int A_W   = 34;   // beta difference
  localparam int B_W   = 35;   // sum of up to four terms
  localparam int LO_W  = 18;   // low split of the b operand
  localparam int ACC_W = 72;
  localparam int T_W   = 32;   // scaled soft-plus table value
  localparam logic [ACC_W-1:0] SP_LIMIT = ACC_W'(SP_STEPS) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] MAX32 = ACC_W'(32'sh7fffffff);
  localparam logic signed [ACC_W-1:0] MIN32 = $signed({{(ACC_W-32){1'b1}}, 32'h80000000});

  // configuration registers
  logic [1:0]         mode;
  logic signed [31:0] beta_sim;
  logic signed [31:0] beta_target;
  logic signed [31:0] energy_shift;
  logic signed [31:0] weight_offset;
  logic [6:0]         replica_count;

  tlwr_state_t state, state_next;

  // replica tables, one synchronous read port each
  logic signed [31:0] off_mem  [MAX_REPLICAS];
  logic signed [31:0] beta_mem [MAX_REPLICAS];
  logic signed [31:0] rd_off;
  logic signed [31:0] rd_beta;
  logic               mem_we;
  logic [IDX_W-1:0]   waddr;

  // datapath
  logic signed [31:0]        e_q;
  logic signed [A_W-1:0]     mul_a;
  logic signed [B_W-1:0]     mul_b;
  logic signed [A_W+LO_W:0]  plo;
  logic signed [A_W+B_W-LO_W-1:0] phi;
  logic signed [ACC_W-1:0]   mq;
  logic signed [ACC_W-1:0]   res_acc;
  logic signed [ACC_W-1:0]   lse;
  logic signed [ACC_W-1:0]   xr;
  logic signed [ACC_W-1:0]   mreg;
  logic [ACC_W-1:0]          dreg;
  logic [T_W-1:0]            spv;
  logic [1:0]                phase;
  logic [IDX_W-1:0]          idx;
  logic [IDX_W-1:0]          idx_last;
  logic signed [31:0]        s_q;
  logic signed [31:0]        r_q;

  // combinational helpers
  logic signed [ACC_W-1:0] x_new;
  logic signed [ACC_W-1:0] fin;
  logic                    idx_at_last;
  logic [4:0]              sp_k;
  logic [T_W-1:0]          t0;
  logic [T_W-1:0]          t1;
  logic [63:0]             sp_prod;
  logic [T_W-1:0]          sp_val;

  function automatic logic [T_W-1:0] sp_scaled(input logic [4:0] k);
    logic [47:0] tmp;
    tmp = 48'(sp_base(k)) << FRAC_BITS;
    return T_W'(tmp >> 16);
  endfunction

  assign idx_at_last = (idx == idx_last);
  assign x_new       = ACC_W'(rd_off) + mq;

  // soft-plus: table lookup and linear interpolation on the half-step grid
  always_comb begin
    sp_k    = dreg[FRAC_BITS-1 +: 5];
    t0      = sp_scaled(sp_k);
    t1      = sp_scaled(sp_k + 5'd1);
    sp_prod = 64'(t0 - t1) * 64'(dreg[FRAC_BITS-2:0]);
    sp_val  = t0 - T_W'(sp_prod >> (FRAC_BITS - 1));
  end

  // final sum before clipping
  always_comb begin
    if (mode == MODE_REPLICA) begin
      fin = res_acc - lse - ACC_W'(weight_offset);
    end else begin
      fin = res_acc - ACC_W'(weight_offset);
    end
  end

  // control outputs
  always_comb begin
    busy   = (state != ST_IDLE);
    waddr  = IDX_W'(entry_index);
    mem_we = (state == ST_IDLE) && start && (op == OP_LOAD)
             && (int'(entry_index) < MAX_REPLICAS);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && op == OP_SAMPLE) state_next = ST_MUL_LO;
      end
      ST_MUL_LO:  state_next = ST_MUL_HI;
      ST_MUL_HI:  state_next = ST_MUL_SUM;
      ST_MUL_SUM: state_next = ST_POST;
      ST_POST: begin
        if (mode == MODE_TWO_TEMP) begin
          state_next = (phase == 2'd2) ? ST_FINAL : ST_MUL_LO;
        end else if (mode == MODE_REPLICA) begin
          if (phase == 2'd0) begin
            state_next = ST_RD;
          end else if (idx != '0) begin
            state_next = ST_CMP;
          end else begin
            state_next = idx_at_last ? ST_FINAL : ST_RD;
          end
        end else begin
          state_next = ST_FINAL;
        end
      end
      ST_RD:      state_next = ST_RD_DATA;
      ST_RD_DATA: state_next = ST_MUL_LO;
      ST_CMP:     state_next = ST_SOFT;
      ST_SOFT:    state_next = ST_SP_ADD;
      ST_SP_ADD:  state_next = idx_at_last ? ST_FINAL : ST_RD;
      ST_FINAL:   state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // table memories
  always_ff @(posedge clk) begin
    if (mem_we) begin
      off_mem[waddr]  <= entry_offset;
      beta_mem[waddr] <= entry_beta;
    end
    rd_off  <= off_mem[idx];
    rd_beta <= beta_mem[idx];
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      done          <= 1'b0;
      mode          <= MODE_BIAS_SUM;
      beta_sim      <= 32'sd65536;
      beta_target   <= 32'sd65536;
      energy_shift  <= '0;
      weight_offset <= '0;
      replica_count <= 7'd1;
    end else begin
      state <= state_next;
      done  <= ((state == ST_IDLE) && start && (op == OP_LOAD)) || (state == ST_FINAL);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE:          mode          <= cfg_data[1:0];
          REG_BETA_SIM:      beta_sim      <= $signed(cfg_data);
          REG_BETA_TARGET:   beta_target   <= $signed(cfg_data);
          REG_ENERGY_SHIFT:  energy_shift  <= $signed(cfg_data);
          REG_WEIGHT_OFFSET: weight_offset <= $signed(cfg_data);
          REG_REPLICA_COUNT: replica_count <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start && op == OP_LOAD) begin
          log_weight   <= '0;
          weight_valid <= 1'b0;
          saturated    <= 1'b0;
        end
        e_q   <= first_term;
        s_q   <= energy_shift;
        r_q   <= rest_sum;
        phase <= 2'd0;
        idx   <= '0;
        if (replica_count == 7'd0) begin
          idx_last <= '0;
        end else if (int'(replica_count) > MAX_REPLICAS) begin
          idx_last <= IDX_W'(MAX_REPLICAS - 1);
        end else begin
          idx_last <= IDX_W'(replica_count - 7'd1);
        end
        if (mode == MODE_TWO_TEMP) begin
          mul_a <= A_W'(beta_sim);
          mul_b <= B_W'(second_term);
        end else if (mode == MODE_REPLICA) begin
          mul_a <= A_W'(beta_target);
          mul_b <= B_W'(energy_shift) + B_W'(second_term) + B_W'(rest_sum);
        end else begin
          mul_a <= A_W'(beta_target);
          mul_b <= B_W'(energy_shift) + B_W'(first_term) + B_W'(second_term)
                   + B_W'(rest_sum);
        end
      end
      ST_MUL_LO: plo <= mul_a * $signed({1'b0, mul_b[LO_W-1:0]});
      ST_MUL_HI: phi <= mul_a * $signed(mul_b[B_W-1:LO_W]);
      ST_MUL_SUM: mq <= ((ACC_W'(phi) <<< LO_W) + ACC_W'(plo)) >>> FRAC_BITS;
      ST_POST: begin
        if (mode == MODE_TWO_TEMP) begin
          res_acc <= (phase == 2'd0) ? mq : res_acc + mq;
          phase   <= phase + 2'd1;
          if (phase == 2'd0) begin
            mul_a <= A_W'(beta_sim) - A_W'(beta_target);
            mul_b <= B_W'(e_q);
          end else begin
            mul_a <= A_W'(beta_target);
            mul_b <= B_W'(s_q) + B_W'(r_q);
          end
        end else if (mode == MODE_REPLICA) begin
          if (phase == 2'd0) begin
            res_acc <= mq;
            phase   <= 2'd1;
          end else if (idx != '0) begin
            xr <= x_new;
          end else begin
            lse <= x_new;
            if (!idx_at_last) idx <= idx + 1'b1;
          end
        end else begin
          res_acc <= mq;
        end
      end
      ST_RD: ;
      ST_RD_DATA: begin
        mul_a <= A_W'(beta_target) - A_W'(rd_beta);
        mul_b <= B_W'(e_q);
      end
      ST_CMP: begin
        if (lse > xr) begin
          mreg <= lse;
          dreg <= lse - xr;
        end else begin
          mreg <= xr;
          dreg <= xr - lse;
        end
      end
      ST_SOFT: spv <= (dreg >= SP_LIMIT) ? '0 : sp_val;
      ST_SP_ADD: begin
        lse <= mreg + ACC_W'(spv);
        if (!idx_at_last) idx <= idx + 1'b1;
      end
      ST_FINAL: begin
        weight_valid <= 1'b1;
        if (fin > MAX32) begin
          log_weight <= 32'sh7fffffff;
          saturated  <= 1'b1;
        end else if (fin < MIN32) begin
          log_weight <= 32'sh80000000;
          saturated  <= 1'b1;
        end else begin
          log_weight <= fin[31:0];
          saturated  <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // a result strobe only follows a load transfer or the end of a sample
  `TLWR_ASSERT(a_done_source, done |-> $past(state == ST_FINAL || (start && !busy && op == OP_LOAD)))
  // an accepted sample keeps the block busy
  `TLWR_ASSERT_NEXT(a_sample_busy, start && !busy && op == OP_SAMPLE, busy)
  // clipping is only reported on a sample result
  `TLWR_ASSERT(a_sat_valid, (done && saturated) |-> weight_valid)
  // the replica walk never passes the last entry in use
  `TLWR_ASSERT(a_idx_bound, (state == ST_RD) |-> (idx <= idx_last))

endmodule
